// ===== src/tcli_pkg.sv =====
package tcli_pkg;

  // table geometry
  localparam int MaxNodes = 512;
  localparam int AddrW    = $clog2(MaxNodes);
  localparam int CountW   = 10;
  localparam int DataW    = 32;

  // one lagrange term quotient, magnitude clipped to 2^60
  localparam int QuotW = 61;
  localparam logic [QuotW-1:0] TermLim = QuotW'(1) << 60;

  // result of a flagged query: -1.0 in q16.16
  localparam logic [DataW-1:0] FlagValue = 32'hFFFF_0000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

endpackage

// ===== src/tcli_term_unit.sv =====
module tcli_term_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [31:0]                 num_fac_i [4],
  input  logic [31:0]                 den_fac_i [3],
  output logic                        done_o,
  output logic [tcli_pkg::QuotW-1:0]  quot_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

  state_e       state_q;
  logic [2:0]   fac_q;
  logic [1:0]   chunk_q;
  logic [6:0]   cnt_q;
  logic         done_q;
  logic [31:0]  carry_q;
  logic [127:0] num_q;
  logic [127:0] den_q;
  logic [95:0]  rem_q;

  logic [31:0]  mult_m;
  logic [31:0]  acc_chunk;
  logic [63:0]  mul_p;
  logic [63:0]  mac;
  logic [96:0]  rem_sh;
  logic [96:0]  rem_sub;
  logic         rem_ge;
  logic         over;

  // factor select: four numerator factors, then three denominator factors
  always_comb begin
    case (fac_q)
      3'd0:    mult_m = num_fac_i[0];
      3'd1:    mult_m = num_fac_i[1];
      3'd2:    mult_m = num_fac_i[2];
      3'd3:    mult_m = num_fac_i[3];
      3'd4:    mult_m = den_fac_i[0];
      3'd5:    mult_m = den_fac_i[1];
      3'd6:    mult_m = den_fac_i[2];
      default: mult_m = '0;
    endcase
  end

  // one 32x32 chunk of the wide product per cycle
  assign acc_chunk = fac_q[2] ? den_q[{chunk_q, 5'b0} +: 32] : num_q[{chunk_q, 5'b0} +: 32];
  assign mul_p     = 64'(acc_chunk) * 64'(mult_m);
  assign mac       = mul_p + 64'(carry_q);

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem_q, num_q[127]};
  assign rem_sub = rem_sh - {1'b0, den_q[95:0]};
  assign rem_ge  = rem_sh >= {1'b0, den_q[95:0]};

  // clip the quotient
  assign over   = (|num_q[127:61]) || (num_q[60:0] > tcli_pkg::TermLim);
  assign quot_o = over ? tcli_pkg::TermLim : num_q[60:0];
  assign done_o = done_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fac_q   <= '0;
      chunk_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_MUL;
            fac_q   <= '0;
            chunk_q <= '0;
          end
        end
        ST_MUL: begin
          chunk_q <= chunk_q + 2'd1;
          if (chunk_q == 2'd3) begin
            fac_q <= fac_q + 3'd1;
            if (fac_q == 3'd6) begin
              state_q <= ST_DIV;
              cnt_q   <= '0;
            end
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // product and division registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      num_q   <= 128'd1;
      den_q   <= 128'd1;
      carry_q <= '0;
      rem_q   <= '0;
    end else if (state_q == ST_MUL) begin
      if (fac_q[2]) begin
        den_q[{chunk_q, 5'b0} +: 32] <= mac[31:0];
      end else begin
        num_q[{chunk_q, 5'b0} +: 32] <= mac[31:0];
      end
      carry_q <= (chunk_q == 2'd3) ? 32'd0 : mac[63:32];
    end else if (state_q == ST_DIV) begin
      rem_q <= rem_ge ? rem_sub[95:0] : rem_sh[95:0];
      num_q <= {num_q[126:0], rem_ge};
    end
  end

endmodule

// ===== src/table_cubic_lagrange_interp.sv =====
// Table interpolator. A beat with cmd_i = 0 writes one node (position and value) and
// gives no result. A beat with cmd_i = 1 queries query_pos_i and
// gives exactly one result on value_o/out_of_range_o, marked by done_o for one cycle,
// which the receiver must take as it comes. While busy is high no beat is taken.
// A query runs through one shared term unit: each term has a multiply phase (32x32
// partial products) and a divide phase (one quotient bit per cycle). A query at or
// below node 1 uses one term. Otherwise the interval search reads one node position
// per cycle from the table memory, then four terms follow. Out-of-range queries are
// flagged without running a term. Table entries that were never written read as
// arbitrary data.
module table_cubic_lagrange_interp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [8:0]                    node_index_i,
  input  logic signed [31:0]            node_pos_i,
  input  logic signed [31:0]            node_value_i,
  input  logic signed [31:0]            query_pos_i,
  output logic                          done_o,
  output logic signed [31:0]            value_o,
  output logic                          out_of_range_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcli_pkg::CountW-1:0]   cfg_data_i
);

  localparam int AW = tcli_pkg::AddrW;
  localparam int CW = tcli_pkg::CountW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_LIN,
    ST_LIN0,
    ST_SCAN,
    ST_LOAD,
    ST_DIST,
    ST_TGO,
    ST_TWAIT
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       node_count_q;
  logic [AW-1:0]       j_q;
  logic [2:0]          ld_q;
  logic [1:0]          k_q;
  logic                line_q;
  logic                done_q;
  logic                oor_q;
  logic [31:0]         value_q;

  logic signed [31:0]  x_q;
  logic signed [31:0]  prev_q;
  logic [AW-1:0]       base_q;
  logic signed [31:0]  xn_q [4];
  logic signed [31:0]  yn_q [4];
  logic signed [63:0]  sum_q;

  logic signed [31:0]  pos_mem [tcli_pkg::MaxNodes];
  logic signed [31:0]  val_mem [tcli_pkg::MaxNodes];
  logic signed [31:0]  pos_rd_q;
  logic signed [31:0]  val_rd_q;

  logic [CW-1:0]       nr;
  logic [AW-1:0]       nr_m2;
  logic [AW-1:0]       rd_addr;
  logic                accept;
  logic                wr_en;
  logic                chk_bad;
  logic                lin_take;
  logic                lin_dup;
  logic                scan_hit;
  logic                scan_end;
  logic                dup;
  logic                last_term;
  logic signed [32:0]  d_n [4];
  logic signed [32:0]  d_d [3];
  logic [31:0]         num_fac [4];
  logic [31:0]         den_fac [3];
  logic                neg;
  logic                term_start;
  logic                term_done;
  logic [tcli_pkg::QuotW-1:0] term_q;
  logic signed [63:0]  term_sq;
  logic signed [63:0]  sum_next;

  function automatic logic signed [32:0] diff33(logic signed [31:0] a, logic signed [31:0] b);
    return 33'(a) - 33'(b);
  endfunction

  function automatic logic [31:0] mag32(logic signed [32:0] d);
    logic signed [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // handshakes
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign wr_en       = accept && (cmd_i == tcli_pkg::CMD_WRITE) &&
                       (32'(node_index_i) < tcli_pkg::MaxNodes);
  assign cfg_ready_o = 1'b1;
  assign done_o         = done_q;
  assign value_o        = value_q;
  assign out_of_range_o = oor_q;

  // effective node count
  always_comb begin
    if (node_count_q < CW'(4)) begin
      nr = CW'(4);
    end else if (32'(node_count_q) > tcli_pkg::MaxNodes) begin
      nr = CW'(tcli_pkg::MaxNodes);
    end else begin
      nr = node_count_q;
    end
  end
  assign nr_m2 = AW'(nr - CW'(2));

  // decisions on the word just read
  assign chk_bad   = (x_q < 32'sd0) || (x_q > pos_rd_q);
  assign lin_take  = (x_q <= pos_rd_q);
  assign lin_dup   = (pos_rd_q == xn_q[1]);
  assign scan_hit  = (x_q > prev_q) && (x_q <= pos_rd_q);
  assign scan_end  = (j_q == nr_m2);
  assign dup       = (xn_q[0] == xn_q[1]) || (xn_q[0] == xn_q[2]) || (xn_q[0] == xn_q[3]) ||
                     (xn_q[1] == xn_q[2]) || (xn_q[1] == xn_q[3]) || (xn_q[2] == xn_q[3]);
  assign last_term = line_q || (k_q == 2'd3);

  // table read address
  always_comb begin
    case (state_q)
      ST_IDLE: rd_addr = nr_m2;
      ST_CHK:  rd_addr = AW'(1);
      ST_LIN:  rd_addr = lin_take ? AW'(0) : AW'(2);
      ST_SCAN: rd_addr = j_q + AW'(1);
      ST_LOAD: rd_addr = base_q + AW'(ld_q);
      default: rd_addr = '0;
    endcase
  end

  // node tables
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_mem[AW'(node_index_i)] <= node_pos_i;
      val_mem[AW'(node_index_i)] <= node_value_i;
    end
    pos_rd_q <= pos_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // term factors; the current node always sits in slot 0
  always_comb begin
    if (line_q) begin
      d_n[0] = diff33(yn_q[1], yn_q[0]);
      d_n[1] = diff33(x_q, xn_q[0]);
      d_n[2] = 33'sd1;
      d_n[3] = 33'sd1;
      d_d[0] = diff33(xn_q[1], xn_q[0]);
      d_d[1] = 33'sd1;
      d_d[2] = 33'sd1;
    end else begin
      d_n[0] = 33'(yn_q[0]);
      d_n[1] = diff33(x_q, xn_q[1]);
      d_n[2] = diff33(x_q, xn_q[2]);
      d_n[3] = diff33(x_q, xn_q[3]);
      d_d[0] = diff33(xn_q[0], xn_q[1]);
      d_d[1] = diff33(xn_q[0], xn_q[2]);
      d_d[2] = diff33(xn_q[0], xn_q[3]);
    end
    neg = 1'b0;
    for (int i = 0; i < 4; i++) begin
      num_fac[i] = mag32(d_n[i]);
      neg        = neg ^ d_n[i][32];
    end
    for (int i = 0; i < 3; i++) begin
      den_fac[i] = mag32(d_d[i]);
      neg        = neg ^ d_d[i][32];
    end
  end

  assign term_start = (state_q == ST_TGO);

  tcli_term_unit u_term (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (term_start),
    .num_fac_i (num_fac),
    .den_fac_i (den_fac),
    .done_o    (term_done),
    .quot_o    (term_q)
  );

  // signed term and running sum
  assign term_sq  = neg ? -64'(term_q) : 64'(term_q);
  assign sum_next = sum_q + term_sq;

  // node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CW'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  // query sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      ld_q    <= '0;
      k_q     <= '0;
      line_q  <= 1'b0;
      done_q  <= 1'b0;
      oor_q   <= 1'b0;
      value_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && cmd_i == tcli_pkg::CMD_QUERY) begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (chk_bad) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            oor_q   <= 1'b1;
            value_q <= tcli_pkg::FlagValue;
          end else begin
            state_q <= ST_LIN;
          end
        end
        ST_LIN: begin
          line_q <= lin_take;
          if (lin_take) begin
            state_q <= ST_LIN0;
          end else begin
            state_q <= ST_SCAN;
            j_q     <= AW'(2);
          end
        end
        ST_LIN0: begin
          if (lin_dup) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            oor_q   <= 1'b1;
            value_q <= tcli_pkg::FlagValue;
          end else begin
            state_q <= ST_TGO;
            k_q     <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            state_q <= ST_LOAD;
            ld_q    <= '0;
          end else if (scan_end) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            oor_q   <= 1'b1;
            value_q <= tcli_pkg::FlagValue;
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
        ST_LOAD: begin
          ld_q <= ld_q + 3'd1;
          if (ld_q == 3'd4) begin
            state_q <= ST_DIST;
          end
        end
        ST_DIST: begin
          if (dup) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            oor_q   <= 1'b1;
            value_q <= tcli_pkg::FlagValue;
          end else begin
            state_q <= ST_TGO;
            k_q     <= '0;
          end
        end
        ST_TGO: begin
          state_q <= ST_TWAIT;
        end
        ST_TWAIT: begin
          if (term_done) begin
            if (last_term) begin
              state_q <= ST_IDLE;
              done_q  <= 1'b1;
              oor_q   <= 1'b0;
              value_q <= sat32(sum_next);
            end else begin
              state_q <= ST_TGO;
              k_q     <= k_q + 2'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // query operands and node window
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_q <= query_pos_i;
        end
      end
      ST_LIN: begin
        xn_q[1] <= pos_rd_q;
        yn_q[1] <= val_rd_q;
        prev_q  <= pos_rd_q;
      end
      ST_LIN0: begin
        xn_q[0] <= pos_rd_q;
        yn_q[0] <= val_rd_q;
        sum_q   <= 64'(val_rd_q);
      end
      ST_SCAN: begin
        prev_q <= pos_rd_q;
        if (scan_hit) begin
          base_q <= j_q - AW'(2);
        end
      end
      ST_LOAD: begin
        if (ld_q != 3'd0) begin
          xn_q[0] <= xn_q[1];
          xn_q[1] <= xn_q[2];
          xn_q[2] <= xn_q[3];
          xn_q[3] <= pos_rd_q;
          yn_q[0] <= yn_q[1];
          yn_q[1] <= yn_q[2];
          yn_q[2] <= yn_q[3];
          yn_q[3] <= val_rd_q;
        end
      end
      ST_DIST: begin
        sum_q <= '0;
      end
      ST_TWAIT: begin
        if (term_done) begin
          sum_q <= sum_next;
          if (!last_term) begin
            // rotate the next node into slot 0
            xn_q[0] <= xn_q[1];
            xn_q[1] <= xn_q[2];
            xn_q[2] <= xn_q[3];
            xn_q[3] <= xn_q[0];
            yn_q[0] <= yn_q[1];
            yn_q[1] <= yn_q[2];
            yn_q[2] <= yn_q[3];
            yn_q[3] <= yn_q[0];
          end
        end
      end
      default: ;
    endcase
  end

  // a result beat only closes a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) != ST_IDLE)
    else $error("result beat without a running query");

  // the block is free again when a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy during result beat");

  // a flagged result always carries the flag value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> value_o == tcli_pkg::FlagValue)
    else $error("flagged result with wrong value");

  // the term unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_done |-> state_q == ST_TWAIT)
    else $error("term finished outside wait state");

endmodule
